>>> rtl/dnlcd_pkg.sv
// Shared constants, segment glyph table and per-digit segment placement map.
package dnlcd_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned MAX_POS     = 6;
	localparam int unsigned DIGITS_DEF  = 6;
	localparam int unsigned MEM_BYTES   = 7;
	localparam int unsigned SEG_BITS    = 8;
	localparam int unsigned BCD_DIGIT_W = 4;

	localparam int unsigned BYTE_IDX_W = $clog2(MEM_BYTES);
	localparam int unsigned BIT_IDX_W  = $clog2(SEG_BITS);

	// segment bits in glyph order a,b,c,d,e,f,g,m
	localparam logic [SEG_BITS-1:0] SEG_A = 8'h01;
	localparam logic [SEG_BITS-1:0] SEG_B = 8'h02;
	localparam logic [SEG_BITS-1:0] SEG_C = 8'h04;
	localparam logic [SEG_BITS-1:0] SEG_D = 8'h08;
	localparam logic [SEG_BITS-1:0] SEG_E = 8'h10;
	localparam logic [SEG_BITS-1:0] SEG_F = 8'h20;
	localparam logic [SEG_BITS-1:0] SEG_G = 8'h40;
	localparam logic [SEG_BITS-1:0] SEG_M = 8'h80;

	typedef logic [BCD_DIGIT_W-1:0] bcd_digit_t;

	// control that travels with each item down the converter chain
	typedef struct packed {
		logic valid;
		logic big;   // value exceeded the display's digit capacity
	} dnlcd_ctrl_t;

	// where segment k of digit position p lands in the segment memory
	localparam logic [BYTE_IDX_W-1:0] PLACE_BYTE [MAX_POS][SEG_BITS] = '{
		'{3'd5, 3'd1, 3'd4, 3'd4, 3'd1, 3'd5, 3'd1, 3'd1},
		'{3'd5, 3'd1, 3'd4, 3'd4, 3'd1, 3'd5, 3'd1, 3'd1},
		'{3'd5, 3'd2, 3'd4, 3'd4, 3'd0, 3'd5, 3'd2, 3'd0},
		'{3'd5, 3'd2, 3'd4, 3'd4, 3'd0, 3'd5, 3'd2, 3'd0},
		'{3'd6, 3'd2, 3'd3, 3'd3, 3'd0, 3'd6, 3'd2, 3'd0},
		'{3'd6, 3'd2, 3'd3, 3'd3, 3'd0, 3'd6, 3'd2, 3'd0}
	};

	localparam logic [BIT_IDX_W-1:0] PLACE_BIT [MAX_POS][SEG_BITS] = '{
		'{3'd0, 3'd4, 3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd3},
		'{3'd2, 3'd6, 3'd5, 3'd4, 3'd0, 3'd3, 3'd7, 3'd1},
		'{3'd4, 3'd0, 3'd3, 3'd2, 3'd6, 3'd5, 3'd1, 3'd7},
		'{3'd6, 3'd2, 3'd1, 3'd0, 3'd4, 3'd7, 3'd3, 3'd5},
		'{3'd0, 3'd4, 3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd3},
		'{3'd2, 3'd6, 3'd5, 3'd4, 3'd0, 3'd3, 3'd7, 3'd1}
	};

	function automatic logic [SEG_BITS-1:0] glyph(input bcd_digit_t dig);
		logic [SEG_BITS-1:0] g;
		unique case (dig)
			4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			4'd1:    g = SEG_B | SEG_C;
			4'd2:    g = SEG_A | SEG_B | SEG_M | SEG_G | SEG_E | SEG_D;
			4'd3:    g = SEG_A | SEG_B | SEG_M | SEG_G | SEG_C | SEG_D;
			4'd4:    g = SEG_F | SEG_G | SEG_M | SEG_B | SEG_C;
			4'd5:    g = SEG_A | SEG_F | SEG_G | SEG_M | SEG_C | SEG_D;
			4'd6:    g = SEG_A | SEG_F | SEG_E | SEG_D | SEG_C | SEG_G | SEG_M;
			4'd7:    g = SEG_A | SEG_B | SEG_C;
			4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G | SEG_M;
			4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G | SEG_M;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/dnlcd_cell.sv
// One shift-and-add-3 cell of the pipelined binary to decimal converter.
module dnlcd_cell import dnlcd_pkg::*; #(
	parameter int unsigned DIGITS = DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  dnlcd_ctrl_t                     ctrl_in,
	input  logic [VALUE_W-1:0]              bin_in,
	input  logic [DIGITS*BCD_DIGIT_W-1:0]   bcd_in,
	output dnlcd_ctrl_t                     ctrl_out,
	output logic [VALUE_W-1:0]              bin_out,
	output logic [DIGITS*BCD_DIGIT_W-1:0]   bcd_out
);

	localparam int unsigned BCD_W = DIGITS * BCD_DIGIT_W;

	logic [BCD_W-1:0]   adj;
	logic [BCD_W-1:0]   bcd_next;
	logic               carry;
	dnlcd_ctrl_t        ctrl_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;

	// add 3 to every digit of 5 or more, then shift in the next binary bit;
	// the bit leaving the top digit means the value wrapped past the display
	always_comb begin
		adj = bcd_in;
		for (int d = 0; d < DIGITS; d++) begin
			if (adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
				adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] = adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
			end
		end
		carry    = adj[BCD_W-1];
		bcd_next = {adj[BCD_W-2:0], bin_in[VALUE_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q.valid <= ctrl_in.valid;
			ctrl_q.big   <= ctrl_in.big | carry;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bin_q <= {bin_in[VALUE_W-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign ctrl_out = ctrl_q;
	assign bin_out  = bin_q;
	assign bcd_out  = bcd_q;

endmodule

>>> rtl/dnlcd_scatter.sv
// Digit count, glyph lookup and scatter into the segment memory output register.
module dnlcd_scatter import dnlcd_pkg::*; #(
	parameter int unsigned DIGITS = DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  dnlcd_ctrl_t                         ctrl_in,
	input  logic [DIGITS*BCD_DIGIT_W-1:0]       bcd_in,
	output logic                                out_valid,
	output logic [MEM_BYTES-1:0][SEG_BITS-1:0]  seg_mem
);

	logic [MEM_BYTES-1:0][SEG_BITS-1:0] mem_q;
	logic [MEM_BYTES-1:0][SEG_BITS-1:0] mem_next;
	logic [DIGITS-1:0]                  show;
	logic                               out_valid_q;

	always_comb begin
		logic               nz;
		logic [SEG_BITS-1:0] g;
		nz       = 1'b0;
		g        = '0;
		mem_next = mem_q;
		// a position is shown if any digit at or above it is nonzero, if big is set, or if it is position 0
		for (int p = DIGITS - 1; p >= 0; p--) begin
			nz      = nz | (bcd_in[p*BCD_DIGIT_W +: BCD_DIGIT_W] != '0);
			show[p] = nz | ctrl_in.big | (p == 0);
		end
		for (int p = 0; p < DIGITS; p++) begin
			if (show[p]) begin
				g = glyph(bcd_in[p*BCD_DIGIT_W +: BCD_DIGIT_W]);
				for (int k = 0; k < SEG_BITS; k++) begin
					mem_next[PLACE_BYTE[p][k]][PLACE_BIT[p][k]] = g[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mem_q       <= '0;
		end else if (en) begin
			out_valid_q <= ctrl_in.valid;
			if (ctrl_in.valid) begin
				mem_q <= mem_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign seg_mem   = mem_q;

endmodule

>>> rtl/decimal_number_to_lcd_segments_unit.sv
// Top level: decimal number to LCD segment memory, converter chain plus scatter stage.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  input   | in_valid / in_ready  | value (32 bit unsigned)
//  output  | out_valid / out_ready| seg_byte0 .. seg_byte6 (8 bit each)
//
//  A row of 32 converter cells turns the value into its low DIGITS decimal
//  digits, one input bit per cell; each cell registers its item, and the scatter
//  stage registers the result. One item enters per cycle unless a held result
//  stalls the chain; the chain holds up to 32 items in flight.
//  Reset clears the segment memory to all zeros and empties the chain.
//  A held result stalls the whole chain; in_ready is low only then.
module decimal_number_to_lcd_segments_unit import dnlcd_pkg::*; #(
	parameter int unsigned DIGITS = DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [VALUE_W-1:0]   value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SEG_BITS-1:0]  seg_byte0,
	output logic [SEG_BITS-1:0]  seg_byte1,
	output logic [SEG_BITS-1:0]  seg_byte2,
	output logic [SEG_BITS-1:0]  seg_byte3,
	output logic [SEG_BITS-1:0]  seg_byte4,
	output logic [SEG_BITS-1:0]  seg_byte5,
	output logic [SEG_BITS-1:0]  seg_byte6
);

	localparam int unsigned BCD_W = DIGITS * BCD_DIGIT_W;

	// chain links: index 0 is the input port, index VALUE_W the last cell
	dnlcd_ctrl_t          ctrl_chain [VALUE_W+1];
	logic [VALUE_W-1:0]   bin_chain  [VALUE_W+1];
	logic [BCD_W-1:0]     bcd_chain  [VALUE_W+1];

	logic                                advance;
	logic [MEM_BYTES-1:0][SEG_BITS-1:0]  seg_mem;

	// advance every stage together whenever the output register is free
	// or its result is taken in this cycle
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// feed the chain: empty decimal accumulator, raw binary value
	assign ctrl_chain[0].valid = in_valid;
	assign ctrl_chain[0].big   = 1'b0;
	assign bin_chain[0]        = value;
	assign bcd_chain[0]        = '0;

	// one cell per input bit, MSB first
	for (genvar i = 0; i < VALUE_W; i++) begin : g_cell
		dnlcd_cell #(
			.DIGITS (DIGITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.ctrl_in  (ctrl_chain[i]),
			.bin_in   (bin_chain[i]),
			.bcd_in   (bcd_chain[i]),
			.ctrl_out (ctrl_chain[i+1]),
			.bin_out  (bin_chain[i+1]),
			.bcd_out  (bcd_chain[i+1])
		);
	end

	// count digits, look up glyphs and update the segment memory,
	// which doubles as the output register
	dnlcd_scatter #(
		.DIGITS (DIGITS)
	) u_scatter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.ctrl_in   (ctrl_chain[VALUE_W]),
		.bcd_in    (bcd_chain[VALUE_W]),
		.out_valid (out_valid),
		.seg_mem   (seg_mem)
	);

	assign seg_byte0 = seg_mem[0];
	assign seg_byte1 = seg_mem[1];
	assign seg_byte2 = seg_mem[2];
	assign seg_byte3 = seg_mem[3];
	assign seg_byte4 = seg_mem[4];
	assign seg_byte5 = seg_mem[5];
	assign seg_byte6 = seg_mem[6];

	// unmapped bits of bytes 3 and 6 never carry a segment
	a_unused_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_byte3[3:0] == 4'h0) && (seg_byte6[7:4] == 4'h0))
		else $error("unmapped segment memory bits set");

	// segment memory moves only when a converted item lands in the output
	a_mem_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && ctrl_chain[VALUE_W].valid) |=>
		$stable({seg_byte0, seg_byte1, seg_byte2, seg_byte3,
			seg_byte4, seg_byte5, seg_byte6}))
		else $error("segment memory changed without an update");

	// a result appears only from an item leaving the last cell
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl_chain[VALUE_W].valid) && $past(advance))
		else $error("result without an item leaving the chain");

endmodule
